>>> design/tmmt_pkg.sv
package tmmt_pkg;

  localparam int unsigned LocalRamBytes = 1024;
  localparam int unsigned MapBytes      = 512;
  localparam int unsigned LocalAw       = $clog2(LocalRamBytes);
  localparam int unsigned MapAw         = $clog2(MapBytes);

  localparam logic [7:0]  HaltOpcode    = 8'h76;
  localparam logic [7:0]  NopOpcode     = 8'h00;
  localparam logic [15:0] TrapBase      = 16'h0BF0;
  localparam logic [3:0]  TrapReads     = 4'd15;
  localparam logic [7:0]  CauseAll      = 8'hBF;
  localparam logic [7:0]  CauseHaltTrap = 8'hBB;
  localparam logic [3:0]  SwitchFetches = 4'd8;

  // Access targets reported with each result.
  localparam logic [2:0] TgtSys = 3'd0;
  localparam logic [2:0] TgtRam = 3'd1;
  localparam logic [2:0] TgtReg = 3'd2;
  localparam logic [2:0] TgtMap = 3'd3;
  localparam logic [2:0] TgtRom = 3'd4;
  localparam logic [2:0] TgtFpu = 3'd5;
  localparam logic [2:0] TgtIgn = 3'd6;

  // Configuration register indexes.
  localparam logic [2:0] CfgSwitch  = 3'd0;
  localparam logic [2:0] CfgKeyb    = 3'd1;
  localparam logic [2:0] CfgRun     = 3'd2;
  localparam logic [2:0] CfgTrapAdr = 3'd3;
  localparam logic [2:0] CfgFpuStat = 3'd4;

  typedef enum logic [1:0] {
    StIdle,
    StDecode,
    StFinish,
    StOutput
  } ctrl_state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic mem_read;
    logic finish;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] switch_setting;
    logic [7:0] keyboard_setting;
    logic       run_enable;
    logic [7:0] trap_address_value;
    logic [7:0] fpu_status_value;
  } cfg_t;

  function automatic logic is_prefix(input logic [7:0] b);
    return (b == 8'hED) || (b == 8'hDD) || (b == 8'hFD) || (b == 8'hCB);
  endfunction

endpackage

>>> design/tmmt_ctrl.sv
module tmmt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tmmt_pkg::dp_cmd_t    cmd_o
);

  tmmt_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state: capture, memory read, state update, then hand off to output.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tmmt_pkg::StIdle:   if (in_valid_i) state_d = tmmt_pkg::StDecode;
      tmmt_pkg::StDecode: state_d = tmmt_pkg::StFinish;
      tmmt_pkg::StFinish: state_d = tmmt_pkg::StOutput;
      tmmt_pkg::StOutput: if (out_free) state_d = tmmt_pkg::StIdle;
      default:            state_d = tmmt_pkg::StIdle;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      tmmt_pkg::StIdle: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      tmmt_pkg::StDecode: cmd_o.mem_read = 1'b1;
      tmmt_pkg::StFinish: cmd_o.finish = 1'b1;
      tmmt_pkg::StOutput: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tmmt_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/tmmt_datapath.sv
module tmmt_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tmmt_pkg::dp_cmd_t cmd_i,
  input  tmmt_pkg::cfg_t    cfg_i,
  input  logic              operation_i,
  input  logic [15:0]       address_i,
  input  logic [7:0]        write_data_i,
  input  logic              opcode_fetch_i,
  input  logic [7:0]        bus_read_data_i,
  output logic [7:0]        read_data_o,
  output logic [2:0]        target_o,
  output logic [23:0]       physical_address_o,
  output logic [7:0]        page_attributes_o,
  output logic [10:0]       rom_address_o,
  output logic              trap_taken_o,
  output logic [7:0]        front_panel_segment_o,
  output logic [7:0]        front_panel_column_o
);

  // Memories.
  logic [7:0] local_mem [tmmt_pkg::LocalRamBytes];
  logic [7:0] map_mem   [tmmt_pkg::MapBytes];
  logic [7:0] ram_rd_q, frame_rd_q, attr_rd_q;

  // Captured transaction.
  logic        wr_q, m1_q;
  logic [15:0] addr_q;
  logic [7:0]  wdata_q, bus_q;

  // Architectural state.
  logic [7:0] task_cur_q, task_cur_d, task_pend_q, task_pend_d, mask_q, mask_d;
  logic [3:0] trap_cnt_q, trap_cnt_d, sw_delay_q, sw_delay_d;
  logic [7:0] cause_q, cause_d, seg_q, seg_d, col_q, col_d;
  logic [7:0] fdata_q, fdata_d, fcmd_q, fcmd_d;
  logic       prefix_q, prefix_d, rom_half_q, rom_half_d;

  // Result registers.
  logic [7:0]  rd_q, rd_d, attr_q, attr_d;
  logic [2:0]  tgt_q, tgt_d;
  logic [23:0] pa_q, pa_d;
  logic [10:0] rom_q, rom_d;
  logic        trap_q, trap_d;

  // Pre-decode values from the capture inputs and current state.
  localparam int unsigned MapAwIdx = tmmt_pkg::MapAw;
  logic [15:0] eff_addr;
  logic [3:0]  cnt_next, dly_next;
  logic [7:0]  task_next;
  logic        cap_m1;
  logic [MapAwIdx-1:0] map_idx;

  always_comb begin
    cap_m1    = opcode_fetch_i && !operation_i;
    eff_addr  = address_i;
    cnt_next  = trap_cnt_q;
    dly_next  = sw_delay_q;
    task_next = task_cur_q;
    if (!operation_i) begin
      if (trap_cnt_q != 4'd0 && cfg_i.run_enable) begin
        eff_addr = tmmt_pkg::TrapBase + 16'(tmmt_pkg::TrapReads - trap_cnt_q);
        cnt_next = trap_cnt_q - 4'd1;
      end
      if (sw_delay_q != 4'd0) begin
        if (opcode_fetch_i) dly_next = sw_delay_q - 4'd1;
        if (dly_next == 4'd0) task_next = task_pend_q;
      end
    end
  end

  assign map_idx = {task_cur_q[3:0], addr_q[15:12], 1'b0};

  // Capture the transaction and the pre-decode state.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      wr_q    <= operation_i;
      m1_q    <= cap_m1;
      addr_q  <= eff_addr;
      wdata_q <= write_data_i;
      bus_q   <= bus_read_data_i;
    end
  end

  logic is_local;
  assign is_local = (task_cur_q[3:0] == 4'd0) && (addr_q < 16'h1000);

  // Memory ports: one local RAM read, two map RAM reads; written at finish.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_read) begin
      ram_rd_q   <= local_mem[addr_q[tmmt_pkg::LocalAw-1:0]];
      frame_rd_q <= map_mem[map_idx];
      attr_rd_q  <= map_mem[map_idx | MapAwIdx'(1)];
    end
    if (cmd_i.finish && wr_q && is_local) begin
      if (addr_q[11:10] == 2'b00) local_mem[addr_q[tmmt_pkg::LocalAw-1:0]] <= wdata_q;
      if (addr_q[11:9] == 3'b011) map_mem[addr_q[MapAwIdx-1:0]] <= wdata_q;
    end
  end

  // Decode and state update.
  always_comb begin
    task_cur_d = task_cur_q; task_pend_d = task_pend_q; mask_d = mask_q;
    trap_cnt_d = trap_cnt_q; sw_delay_d = sw_delay_q; cause_d = cause_q;
    seg_d = seg_q; col_d = col_q; fdata_d = fdata_q; fcmd_d = fcmd_q;
    prefix_d = prefix_q; rom_half_d = rom_half_q;
    rd_d = 8'd0; tgt_d = tmmt_pkg::TgtIgn; pa_d = '0; attr_d = '0; rom_d = '0;
    trap_d = 1'b0;
    if (!is_local) begin
      tgt_d  = tmmt_pkg::TgtSys;
      pa_d   = {task_cur_q[7:4], frame_rd_q, addr_q[11:0]};
      attr_d = attr_rd_q;
      if (!wr_q) rd_d = bus_q;
    end else begin
      unique case (addr_q[11:9])
        3'b000, 3'b001: begin
          tgt_d = tmmt_pkg::TgtRam;
          if (!wr_q) rd_d = ram_rd_q;
        end
        3'b010: begin
          tgt_d = tmmt_pkg::TgtReg;
          if (wr_q) begin
            unique case (addr_q[1:0])
              2'd0: seg_d = wdata_q;
              2'd1: col_d = wdata_q;
              2'd2: begin
                task_pend_d = wdata_q;
                rom_half_d  = 1'b1;
                sw_delay_d  = tmmt_pkg::SwitchFetches;
              end
              default: mask_d = wdata_q;
            endcase
          end else begin
            unique case (addr_q[1:0])
              2'd0:    rd_d = cfg_i.trap_address_value;
              2'd1:    rd_d = cfg_i.keyboard_setting;
              2'd2:    rd_d = cfg_i.switch_setting;
              default: rd_d = cause_q;
            endcase
          end
        end
        3'b011: tgt_d = tmmt_pkg::TgtMap;
        3'b100, 3'b101: begin
          if (!wr_q) begin
            tgt_d = tmmt_pkg::TgtRom;
            rom_d = {rom_half_q, addr_q[9:0]};
            rd_d  = bus_q;
          end
        end
        3'b110: begin
          tgt_d = tmmt_pkg::TgtFpu;
          if (addr_q[3]) begin
            if (wr_q) fcmd_d = wdata_q;
            else rd_d = cfg_i.fpu_status_value;
          end else begin
            if (wr_q) fdata_d = wdata_q;
            else rd_d = fdata_q;
          end
        end
        default: ;
      endcase
    end
    if (!wr_q) begin
      if (task_cur_q[3:0] != 4'd0 && m1_q && rd_d == tmmt_pkg::HaltOpcode
          && !prefix_q && mask_q[4]) begin
        task_cur_d = 8'd0;
        trap_cnt_d = tmmt_pkg::TrapReads;
        cause_d    = tmmt_pkg::CauseHaltTrap;
        rd_d       = tmmt_pkg::NopOpcode;
        trap_d     = 1'b1;
      end
      prefix_d = cfg_i.run_enable && m1_q && tmmt_pkg::is_prefix(rd_d);
    end
  end

  // State registers: pre-decode updates at capture, decode updates at finish.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_cur_q <= '0; task_pend_q <= '0; mask_q <= '0;
      trap_cnt_q <= tmmt_pkg::TrapReads; sw_delay_q <= '0;
      cause_q <= tmmt_pkg::CauseAll; prefix_q <= 1'b0; rom_half_q <= 1'b0;
      seg_q <= '0; col_q <= '0; fdata_q <= '0; fcmd_q <= '0;
    end else if (cmd_i.capture) begin
      trap_cnt_q <= cnt_next;
      sw_delay_q <= dly_next;
      task_cur_q <= task_next;
    end else if (cmd_i.finish) begin
      task_cur_q <= task_cur_d; task_pend_q <= task_pend_d; mask_q <= mask_d;
      trap_cnt_q <= trap_cnt_d; sw_delay_q <= sw_delay_d; cause_q <= cause_d;
      prefix_q <= prefix_d; rom_half_q <= rom_half_d;
      seg_q <= seg_d; col_q <= col_d; fdata_q <= fdata_d; fcmd_q <= fcmd_d;
    end
  end

  // Result registers, then the output register.
  logic [7:0]  res_rd_q, res_attr_q;
  logic [2:0]  res_tgt_q;
  logic [23:0] res_pa_q;
  logic [10:0] res_rom_q;
  logic        res_trap_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_rd_q <= rd_d; res_tgt_q <= tgt_d; res_pa_q <= pa_d;
      res_attr_q <= attr_d; res_rom_q <= rom_d; res_trap_q <= trap_d;
    end
    if (cmd_i.out_load) begin
      rd_q <= res_rd_q; tgt_q <= res_tgt_q; pa_q <= res_pa_q;
      attr_q <= res_attr_q; rom_q <= res_rom_q; trap_q <= res_trap_q;
    end
  end

  logic [7:0] oseg_q, ocol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oseg_q <= '0;
      ocol_q <= '0;
    end else if (cmd_i.out_load) begin
      oseg_q <= seg_q;
      ocol_q <= col_q;
    end
  end

  assign read_data_o           = rd_q;
  assign target_o              = tgt_q;
  assign physical_address_o    = pa_q;
  assign page_attributes_o     = attr_q;
  assign rom_address_o         = rom_q;
  assign trap_taken_o          = trap_q;
  assign front_panel_segment_o = oseg_q;
  assign front_panel_column_o  = ocol_q;

endmodule

>>> design/task_memory_map_trap_unit.sv
// An accepted transaction passes through capture, memory read, state update and
// output hand-off before its result is shown; a stalled output holds the hand-off.
// No new transaction is taken until the previous one has been handed off.
// Reset: asynchronous, active low; control state, task state, counters and
// configuration return to their defaults. Local RAM and map RAM are not cleared.
module task_memory_map_trap_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic        opcode_fetch_i,
  input  logic [7:0]  bus_read_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic [2:0]  target_o,
  output logic [23:0] physical_address_o,
  output logic [7:0]  page_attributes_o,
  output logic [10:0] rom_address_o,
  output logic        trap_taken_o,
  output logic [7:0]  front_panel_segment_o,
  output logic [7:0]  front_panel_column_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tmmt_pkg::cfg_t    cfg_q;
  tmmt_pkg::dp_cmd_t cmd;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.switch_setting     <= 8'd20;
      cfg_q.keyboard_setting   <= 8'd0;
      cfg_q.run_enable         <= 1'b1;
      cfg_q.trap_address_value <= 8'd0;
      cfg_q.fpu_status_value   <= 8'd0;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      case (paddr[4:2])
        tmmt_pkg::CfgSwitch:  cfg_q.switch_setting     <= pwdata[7:0];
        tmmt_pkg::CfgKeyb:    cfg_q.keyboard_setting   <= pwdata[7:0];
        tmmt_pkg::CfgRun:     cfg_q.run_enable         <= pwdata[0];
        tmmt_pkg::CfgTrapAdr: cfg_q.trap_address_value <= pwdata[7:0];
        tmmt_pkg::CfgFpuStat: cfg_q.fpu_status_value   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Configuration readback.
  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      tmmt_pkg::CfgSwitch:  prdata = {24'd0, cfg_q.switch_setting};
      tmmt_pkg::CfgKeyb:    prdata = {24'd0, cfg_q.keyboard_setting};
      tmmt_pkg::CfgRun:     prdata = {31'd0, cfg_q.run_enable};
      tmmt_pkg::CfgTrapAdr: prdata = {24'd0, cfg_q.trap_address_value};
      tmmt_pkg::CfgFpuStat: prdata = {24'd0, cfg_q.fpu_status_value};
      default:              prdata = '0;
    endcase
  end

  tmmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  tmmt_datapath u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .cfg_i                 (cfg_q),
    .operation_i           (operation_i),
    .address_i             (address_i),
    .write_data_i          (write_data_i),
    .opcode_fetch_i        (opcode_fetch_i),
    .bus_read_data_i       (bus_read_data_i),
    .read_data_o           (read_data_o),
    .target_o              (target_o),
    .physical_address_o    (physical_address_o),
    .page_attributes_o     (page_attributes_o),
    .rom_address_o         (rom_address_o),
    .trap_taken_o          (trap_taken_o),
    .front_panel_segment_o (front_panel_segment_o),
    .front_panel_column_o  (front_panel_column_o)
  );

  // A trapped fetch always delivers a NOP.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && trap_taken_o |-> read_data_o == tmmt_pkg::NopOpcode)
    else $error("trap result without NOP");

  // Only the system bus target carries a translated address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && target_o != tmmt_pkg::TgtSys |-> physical_address_o == 24'd0)
    else $error("address on non-system target");

  // The input is never taken while a result is being loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> in_stall_o)
    else $error("input accepted during output load");

endmodule

>>> tb/task_memory_map_trap_unit_tb.sv
module task_memory_map_trap_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One bus access offered to the unit and the result it produces.
  typedef struct {
    logic        write;
    logic [15:0] address;
    logic [7:0]  wdata;
    logic        fetch;
    logic [7:0]  bus;
  } access_t;

  typedef struct {
    logic [7:0]  rd;
    logic [2:0]  target;
    logic [23:0] pa;
    logic [7:0]  attr;
    logic [10:0] rom;
    logic        trap;
    logic [7:0]  seg;
    logic [7:0]  col;
  } access_result_t;

  // Scalar state of the unit; the memories are kept apart.
  typedef struct {
    logic [7:0] task_cur;
    logic [7:0] task_pend;
    logic [7:0] mask;
    logic [3:0] countdown;
    logic [7:0] cause;
    logic [3:0] sw_delay;
    logic       prefix;
    logic       rom_half;
    logic [7:0] seg;
    logic [7:0] col;
    logic [7:0] fpu_operand;
    logic [7:0] fpu_cmd;
  } unit_state_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        operation_i;
  logic [15:0] address_i;
  logic [7:0]  write_data_i;
  logic        opcode_fetch_i;
  logic [7:0]  bus_read_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  read_data_o;
  logic [2:0]  target_o;
  logic [23:0] physical_address_o;
  logic [7:0]  page_attributes_o;
  logic [10:0] rom_address_o;
  logic        trap_taken_o;
  logic [7:0]  front_panel_segment_o;
  logic [7:0]  front_panel_column_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  task_memory_map_trap_unit DUT (.*);

  // Predictor state.
  unit_state_t    st;
  tmmt_pkg::cfg_t cfg;
  logic [7:0]     lram [1024];
  bit             lram_written [1024];
  logic [7:0]     mapm [512];
  bit             map_written [512];
  logic [15:0]    lram_addrs [$];
  bit             unwritten_hit;

  access_t        pending_items [$];
  access_result_t expected_results [$];
  int             errors;
  int             results_seen;
  bit             calm;
  int             send_gap;
  int             recv_gap;
  int             hold_left;
  bit             hold_done;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic bit is_prefix_byte(logic [7:0] b);
    return b == 8'hED || b == 8'hDD || b == 8'hFD || b == 8'hCB;
  endfunction

  // Computes the result of one access and advances the predicted state.
  function automatic access_result_t predict_access(access_t a);
    access_result_t r;
    logic [15:0]    ad;
    logic           m1;
    logic           loc;
    logic [8:0]     idx;
    r = '{default: '0};
    r.target = tmmt_pkg::TgtIgn;
    ad = a.address;
    m1 = a.fetch;
    if (!a.write) begin
      if (st.countdown != 0 && cfg.run_enable) begin
        ad = tmmt_pkg::TrapBase + 16'(tmmt_pkg::TrapReads - st.countdown);
        st.countdown = st.countdown - 4'd1;
      end
      if (st.sw_delay != 0) begin
        if (m1) st.sw_delay = st.sw_delay - 4'd1;
        if (st.sw_delay == 0) st.task_cur = st.task_pend;
      end
    end else begin
      m1 = 1'b0;
    end
    loc = (st.task_cur[3:0] == 4'd0) && (ad < 16'h1000);
    if (!loc) begin
      // Translation through the current task's map.
      idx = {st.task_cur[3:0], ad[15:12], 1'b0};
      if (!map_written[idx] || !map_written[idx + 9'd1]) unwritten_hit = 1'b1;
      r.pa = {st.task_cur[7:4], mapm[idx], ad[11:0]};
      r.attr = mapm[idx + 9'd1];
      r.target = tmmt_pkg::TgtSys;
      if (!a.write) r.rd = a.bus;
    end else begin
      case (ad[11:9])
        3'd0, 3'd1: begin
          r.target = tmmt_pkg::TgtRam;
          if (a.write) begin
            lram[ad[9:0]] = a.wdata;
            if (!lram_written[ad[9:0]]) lram_addrs.push_back({6'd0, ad[9:0]});
            lram_written[ad[9:0]] = 1'b1;
          end else begin
            if (!lram_written[ad[9:0]]) unwritten_hit = 1'b1;
            r.rd = lram[ad[9:0]];
          end
        end
        3'd2: begin
          r.target = tmmt_pkg::TgtReg;
          if (a.write) begin
            case (ad[1:0])
              2'd0: st.seg = a.wdata;
              2'd1: st.col = a.wdata;
              2'd2: begin
                st.task_pend = a.wdata;
                st.rom_half = 1'b1;
                st.sw_delay = tmmt_pkg::SwitchFetches;
              end
              default: st.mask = a.wdata;
            endcase
          end else begin
            case (ad[1:0])
              2'd0: r.rd = cfg.trap_address_value;
              2'd1: r.rd = cfg.keyboard_setting;
              2'd2: r.rd = cfg.switch_setting;
              default: r.rd = st.cause;
            endcase
          end
        end
        3'd3: begin
          r.target = tmmt_pkg::TgtMap;
          if (a.write) begin
            mapm[ad[8:0]] = a.wdata;
            map_written[ad[8:0]] = 1'b1;
          end
        end
        3'd4, 3'd5: begin
          if (!a.write) begin
            r.target = tmmt_pkg::TgtRom;
            r.rom = {st.rom_half, ad[9:0]};
            r.rd = a.bus;
          end
        end
        3'd6: begin
          r.target = tmmt_pkg::TgtFpu;
          if (ad[3]) begin
            if (a.write) st.fpu_cmd = a.wdata;
            else r.rd = cfg.fpu_status_value;
          end else begin
            if (a.write) st.fpu_operand = a.wdata;
            else r.rd = st.fpu_operand;
          end
        end
        default: ;
      endcase
    end
    if (!a.write) begin
      // Halt trap on an unprefixed HALT fetch in a user task when mask bit 4 is set.
      if (st.task_cur[3:0] != 4'd0 && m1 && r.rd == tmmt_pkg::HaltOpcode && !st.prefix
          && st.mask[4]) begin
        st.task_cur = 8'd0;
        st.countdown = tmmt_pkg::TrapReads;
        st.cause = tmmt_pkg::CauseHaltTrap;
        r.rd = tmmt_pkg::NopOpcode;
        r.trap = 1'b1;
      end
      st.prefix = cfg.run_enable && m1 && is_prefix_byte(r.rd);
    end
    r.seg = st.seg;
    r.col = st.col;
    return r;
  endfunction

  // Keeps every pending task inside the part of the map that was loaded.
  function automatic access_t limit_task(access_t a);
    if (a.write && (a.address & 16'h0E03) == 16'h0402) a.wdata[3:2] = 2'b00;
    return a;
  endfunction

  // Predicts one access and queues it; reads of unwritten RAM become writes.
  function automatic void queue_access(access_t a);
    unit_state_t    snap;
    access_result_t r;
    a = limit_task(a);
    snap = st;
    unwritten_hit = 1'b0;
    r = predict_access(a);
    if (unwritten_hit) begin
      st = snap;
      a.write = 1'b1;
      a = limit_task(a);
      r = predict_access(a);
    end
    pending_items.push_back(a);
    expected_results.push_back(r);
  endfunction

  function automatic void queue_direct(logic w, logic [15:0] ad, logic [7:0] d,
                                       logic f, logic [7:0] b);
    access_t a;
    a.write = w;
    a.address = ad;
    a.wdata = d;
    a.fetch = f;
    a.bus = b;
    queue_access(a);
  endfunction

  // Random access, weighted toward each decode region and toward trap sequences.
  function automatic access_t random_access();
    access_t a;
    int      kind;
    a.write = 1'($urandom_range(0, 1));
    a.address = 16'($urandom);
    a.wdata = 8'($urandom);
    a.fetch = 1'($urandom_range(0, 1));
    a.bus = 8'($urandom);
    case ($urandom_range(0, 9))
      0, 1: a.bus = tmmt_pkg::HaltOpcode;
      2: a.bus = 8'hED;
      3: a.bus = 8'hDD;
      4: a.bus = 8'hFD;
      5: a.bus = 8'hCB;
      default: ;
    endcase
    kind = $urandom_range(0, 12);
    case (kind)
      0: begin
        a.write = 1'b1;
        a.address = {6'd0, a.address[9:0]};
      end
      1: if (lram_addrs.size() != 0) begin
        a.write = 1'b0;
        a.address = lram_addrs[$urandom_range(0, lram_addrs.size() - 1)];
      end
      2: a.address = {4'h0, 3'b010, a.address[8:0]};
      3: a.address = {4'h0, 3'b011, a.address[8:0]};
      4: a.address = {4'h0, 2'b10, a.address[9:0]};
      5: a.address = {4'h0, 3'b110, a.address[8:0]};
      6: a.address = {4'h0, 3'b111, a.address[8:0]};
      7, 8: begin
        if (a.address[15:12] == 4'h0) a.address[15:12] = 4'h1;
        if (kind == 8) begin
          a.write = 1'b0;
          a.fetch = 1'b1;
        end
      end
      9: begin
        a.write = 1'b1;
        a.address = 16'h0403;
        if ($urandom_range(0, 2) != 0) a.wdata[4] = 1'b1;
      end
      10: begin
        a.write = 1'b1;
        a.address = 16'h0402;
      end
      11: begin
        a.write = 1'b0;
        a.fetch = 1'b1;
      end
      default: ;
    endcase
    return a;
  endfunction

  // Driver: presents queued transactions, with random idle bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    access_t a;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      operation_i <= 1'b0;
      address_i <= '0;
      write_data_i <= '0;
      opcode_fetch_i <= 1'b0;
      bus_read_data_i <= '0;
      send_gap = 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (pending_items.size() != 0) begin
        a = pending_items.pop_front();
        in_valid_i <= 1'b1;
        operation_i <= a.write;
        address_i <= a.address;
        write_data_i <= a.wdata;
        opcode_fetch_i <= a.fetch;
        bus_read_data_i <= a.bus;
        if (!calm && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 16);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Monitor: checks each result transaction and drives the output stall.
  always @(posedge clk_i or negedge rst_ni) begin
    access_result_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual read_data %0h", $time,
                   read_data_o);
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("read_data", e.rd, read_data_o);
          check_field("target", e.target, target_o);
          check_field("physical_address", e.pa, physical_address_o);
          check_field("page_attributes", e.attr, page_attributes_o);
          check_field("rom_address", e.rom, rom_address_o);
          check_field("trap_taken", e.trap, trap_taken_o);
          check_field("front_panel_segment", e.seg, front_panel_segment_o);
          check_field("front_panel_column", e.col, front_panel_column_o);
        end
        results_seen++;
      end
      // One long hold-off so that the unit backs up into its input.
      if (!hold_done && results_seen >= 300) begin
        hold_done = 1'b1;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (recv_gap > 0) begin
        out_stall_i <= 1'b1;
        recv_gap--;
      end else begin
        out_stall_i <= 1'b0;
        if (!calm && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 16);
      end
    end
  end

  task automatic write_register(input logic [2:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      tmmt_pkg::CfgSwitch:  cfg.switch_setting = val;
      tmmt_pkg::CfgKeyb:    cfg.keyboard_setting = val;
      tmmt_pkg::CfgRun:     cfg.run_enable = val[0];
      tmmt_pkg::CfgTrapAdr: cfg.trap_address_value = val;
      default:              cfg.fpu_status_value = val;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Stimulus: map load, directed accesses, then random phases over configurations.
  initial begin
    logic [7:0] sw_v [5];
    logic [7:0] kb_v [5];
    logic       run_v [5];
    logic [7:0] ta_v [5];
    logic [7:0] fs_v [5];
    sw_v = '{8'h00, 8'hFF, 8'h5A, 8'h00, 8'hFF};
    kb_v = '{8'h00, 8'hFF, 8'hA5, 8'hFF, 8'h3C};
    run_v = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    ta_v = '{8'h00, 8'hFF, 8'h81, 8'h7E, 8'h00};
    fs_v = '{8'hFF, 8'h00, 8'h42, 8'hFF, 8'h18};
    errors = 0;
    results_seen = 0;
    calm = 1'b0;
    st = '{countdown: tmmt_pkg::TrapReads, cause: tmmt_pkg::CauseAll, default: '0};
    cfg = '{switch_setting: 8'd20, keyboard_setting: 8'd0, run_enable: 1'b1,
            trap_address_value: 8'd0, fpu_status_value: 8'd0};
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Map entries for tasks whose low nibble is 0 to 3.
    for (int i = 0; i < 128; i++) begin
      queue_direct(1'b1, 16'h0600 + 16'(i), 8'($urandom), 1'b0, 8'h00);
    end
    // Board registers, FPU, ROM write, the ignored region and local RAM.
    queue_direct(1'b1, 16'h0400, 8'hFF, 1'b0, 8'h00);
    queue_direct(1'b1, 16'h0401, 8'h00, 1'b0, 8'h00);
    queue_direct(1'b1, 16'h0403, 8'hFF, 1'b0, 8'h00);
    queue_direct(1'b1, 16'h0C00, 8'hA5, 1'b0, 8'h00);
    queue_direct(1'b1, 16'h0C08, 8'h5A, 1'b0, 8'h00);
    queue_direct(1'b1, 16'h0BFF, 8'h11, 1'b0, 8'h00);
    queue_direct(1'b1, 16'h0E00, 8'h22, 1'b0, 8'h00);
    queue_direct(1'b1, 16'h0000, 8'h00, 1'b0, 8'h00);
    queue_direct(1'b1, 16'h03FF, 8'hFF, 1'b0, 8'h00);
    // Reads after reset are replaced by the trap window.
    for (int i = 0; i < 15; i++) queue_direct(1'b0, 16'hFFFF, 8'h00, 1'(i), 8'(i * 17));
    queue_direct(1'b0, 16'h0403, 8'h00, 1'b0, 8'h00);
    queue_direct(1'b0, 16'h0C08, 8'h00, 1'b0, 8'h00);
    queue_direct(1'b0, 16'h0C00, 8'h00, 1'b0, 8'h00);
    queue_direct(1'b0, 16'h0600, 8'h00, 1'b0, 8'h00);
    queue_direct(1'b0, 16'h0FFF, 8'h00, 1'b0, 8'h00);
    queue_direct(1'b0, 16'h03FF, 8'h00, 1'b0, 8'h00);
    queue_direct(1'b0, 16'hFFFF, 8'h00, 1'b0, 8'hFF);
    // Task switch, then a prefixed HALT and a trapping HALT.
    queue_direct(1'b1, 16'h0402, 8'hF1, 1'b0, 8'h00);
    for (int i = 0; i < 8; i++) queue_direct(1'b0, 16'h1234, 8'h00, 1'b1, 8'h00);
    queue_direct(1'b0, 16'h2000, 8'h00, 1'b1, 8'hED);
    queue_direct(1'b0, 16'h2001, 8'h00, 1'b1, tmmt_pkg::HaltOpcode);
    queue_direct(1'b0, 16'h2002, 8'h00, 1'b1, tmmt_pkg::HaltOpcode);
    queue_direct(1'b0, 16'h0402, 8'h00, 1'b0, 8'h00);
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      write_register(tmmt_pkg::CfgSwitch, sw_v[p]);
      write_register(tmmt_pkg::CfgKeyb, kb_v[p]);
      write_register(tmmt_pkg::CfgRun, {7'd0, run_v[p]});
      write_register(tmmt_pkg::CfgTrapAdr, ta_v[p]);
      write_register(tmmt_pkg::CfgFpuStat, fs_v[p]);
      if (p == 4) calm = 1'b1;
      for (int i = 0; i < 185; i++) queue_access(random_access());
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("task_memory_map_trap_unit_tb: clean");
    end else begin
      $display("task_memory_map_trap_unit_tb: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("task_memory_map_trap_unit_tb: errors");
    $finish;
  end

endmodule

>>> filelist.f
design/tmmt_pkg.sv
design/tmmt_ctrl.sv
design/tmmt_datapath.sv
design/task_memory_map_trap_unit.sv
tb/task_memory_map_trap_unit_tb.sv
